// ===== rtl/core/modexp_pkg.sv =====
// Shared types, constants and the microcode program of the modular exponentiation block.
// Used by modexp_datapath and modular_exponentiation; depends on nothing else.
package modexp_pkg;

  localparam int unsigned FIELD_W      = 63;   // base and exponent width
  localparam int unsigned RESULT_W     = 31;   // power_result width
  localparam int unsigned CFG_W        = 31;   // modulus register write width
  localparam int unsigned IN_TDATA_W   = 128;  // two 63-bit fields, padded to bytes
  localparam int unsigned OUT_TDATA_W  = 32;
  localparam int unsigned DIV_W        = 64;   // dividend shifter of the reducer
  localparam int unsigned CNT_W        = 7;    // reduction step count, up to 64
  localparam int unsigned UPC_W        = 4;

  localparam logic [CFG_W-1:0] MODULUS_RESET = 31'd1000000007;

  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LOAD     = 4'd1,  // take a word: exponent, base into the reducer
    OP_RED_STEP = 4'd2,  // one restoring remainder step
    OP_BASE_SET = 4'd3,  // base <= remainder
    OP_MUL_ACC  = 4'd4,  // reducer <= acc * base
    OP_ACC_SET  = 4'd5,  // acc <= remainder
    OP_MUL_SQR  = 4'd6,  // reducer <= base * base
    OP_SQR_SET  = 4'd7,  // base <= remainder, exponent >>= 1
    OP_OUT      = 4'd8   // acc into the output register
  } op_t;

  typedef enum logic [2:0] {
    CND_NONE     = 3'd0,
    CND_ALWAYS   = 3'd1,
    CND_IN_IDLE  = 3'd2,
    CND_RED_MORE = 3'd3,
    CND_EXP_ZERO = 3'd4,
    CND_BIT_CLR  = 3'd5,
    CND_OUT_BUSY = 3'd6
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_bit0;
    logic red_last;
  } dp_status_t;

  localparam logic [UPC_W-1:0] L_IDLE     = 4'd0;
  localparam logic [UPC_W-1:0] L_RED_BASE = 4'd1;
  localparam logic [UPC_W-1:0] L_BASE_SET = 4'd2;
  localparam logic [UPC_W-1:0] L_LOOP     = 4'd3;
  localparam logic [UPC_W-1:0] L_BIT_TEST = 4'd4;
  localparam logic [UPC_W-1:0] L_MUL_ACC  = 4'd5;
  localparam logic [UPC_W-1:0] L_RED_ACC  = 4'd6;
  localparam logic [UPC_W-1:0] L_ACC_SET  = 4'd7;
  localparam logic [UPC_W-1:0] L_MUL_SQR  = 4'd8;
  localparam logic [UPC_W-1:0] L_RED_SQR  = 4'd9;
  localparam logic [UPC_W-1:0] L_SQR_SET  = 4'd10;
  localparam logic [UPC_W-1:0] L_OUT      = 4'd11;
  localparam logic [UPC_W-1:0] L_DONE     = 4'd12;

  // Jump to target when the condition holds, else advance.
  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] upc);
    uword_t w;
    case (upc)
      L_IDLE:     w = '{OP_LOAD,     CND_IN_IDLE,  L_IDLE};
      L_RED_BASE: w = '{OP_RED_STEP, CND_RED_MORE, L_RED_BASE};
      L_BASE_SET: w = '{OP_BASE_SET, CND_NONE,     L_IDLE};
      L_LOOP:     w = '{OP_NONE,     CND_EXP_ZERO, L_OUT};
      L_BIT_TEST: w = '{OP_NONE,     CND_BIT_CLR,  L_MUL_SQR};
      L_MUL_ACC:  w = '{OP_MUL_ACC,  CND_NONE,     L_IDLE};
      L_RED_ACC:  w = '{OP_RED_STEP, CND_RED_MORE, L_RED_ACC};
      L_ACC_SET:  w = '{OP_ACC_SET,  CND_NONE,     L_IDLE};
      L_MUL_SQR:  w = '{OP_MUL_SQR,  CND_NONE,     L_IDLE};
      L_RED_SQR:  w = '{OP_RED_STEP, CND_RED_MORE, L_RED_SQR};
      L_SQR_SET:  w = '{OP_SQR_SET,  CND_ALWAYS,   L_LOOP};
      L_OUT:      w = '{OP_OUT,      CND_OUT_BUSY, L_OUT};
      L_DONE:     w = '{OP_NONE,     CND_ALWAYS,   L_IDLE};
      default:    w = '{OP_NONE,     CND_ALWAYS,   L_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/modexp_datapath.sv =====
// Datapath of the modular exponentiation block: accumulator, base, exponent shifter,
// one multiplier and a bit-serial restoring reducer. Driven by ops from modexp_pkg.
module modexp_datapath #(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic                          clk,
  input  modexp_pkg::op_t               op,
  input  logic [modexp_pkg::FIELD_W-1:0] base_value,
  input  logic [modexp_pkg::FIELD_W-1:0] exponent_value,
  input  logic [MOD_BITS-1:0]           modulus,   // already at least two
  output logic [MOD_BITS-1:0]           acc,
  output modexp_pkg::dp_status_t        status
);
  import modexp_pkg::*;

  localparam int unsigned PROD_W = 2 * MOD_BITS;

  logic [MOD_BITS-1:0] base;
  logic [FIELD_W-1:0]  exponent;
  logic [DIV_W-1:0]    dividend;
  logic [MOD_BITS-1:0] rem;
  logic [CNT_W-1:0]    cnt;

  logic [MOD_BITS-1:0] mul_a;
  logic [PROD_W-1:0]   product;
  logic [MOD_BITS:0]   shifted;
  logic [MOD_BITS:0]   diff;
  logic [MOD_BITS-1:0] rem_next;

  assign mul_a   = (op == OP_MUL_ACC) ? acc : base;
  assign product = PROD_W'(mul_a) * PROD_W'(base);

  // One restoring step: bring in the next dividend bit, subtract when it fits.
  assign shifted  = {rem, dividend[DIV_W-1]};
  assign diff     = shifted - (MOD_BITS+1)'(modulus);
  assign rem_next = (shifted >= (MOD_BITS+1)'(modulus)) ? diff[MOD_BITS-1:0]
                                                         : shifted[MOD_BITS-1:0];

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        exponent <= exponent_value;
        dividend <= {base_value, 1'b0};
        cnt      <= CNT_W'(FIELD_W);
        rem      <= '0;
        acc      <= MOD_BITS'(1);
      end
      OP_RED_STEP: begin
        rem      <= rem_next;
        dividend <= {dividend[DIV_W-2:0], 1'b0};
        cnt      <= cnt - CNT_W'(1);
      end
      OP_BASE_SET: begin
        base <= rem;
      end
      OP_MUL_ACC, OP_MUL_SQR: begin
        // left-align the product so the reducer always starts at the top bit
        dividend <= DIV_W'(product) << (DIV_W - PROD_W);
        cnt      <= CNT_W'(PROD_W);
        rem      <= '0;
      end
      OP_ACC_SET: begin
        acc <= rem;
      end
      OP_SQR_SET: begin
        base     <= rem;
        exponent <= exponent >> 1;
      end
      default: begin
      end
    endcase
  end

  assign status.exp_zero = (exponent == '0);
  assign status.exp_bit0 = exponent[0];
  assign status.red_last = (cnt == CNT_W'(1));

endmodule

// ===== rtl/core/modular_exponentiation.sv =====
// Modular exponentiation, right-to-left square-and-multiply, microcoded sequencer.
// The base is first reduced by the modulus; then each exponent bit up to the highest set one
// costs a squaring and its reduction, plus a multiply and its reduction when the bit is set.
// The reducer makes one remainder bit per cycle.
// One word in flight: the next word is taken only after the result has been registered.
// Synchronous reset: modulus 1000000007, sequencer idle, output empty, no word taken.
module modular_exponentiation #(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [modexp_pkg::CFG_W-1:0]       cfg_data,      // modulus
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [62:0] base_value, [125:63] exponent_value, [127:126] zero
  input  logic [modexp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [30:0] power_result, [31] zero
  output logic [modexp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import modexp_pkg::*;

  logic [MOD_BITS-1:0]  modulus;
  logic [MOD_BITS-1:0]  mod_eff;
  logic [UPC_W-1:0]     upc;
  logic [UPC_W-1:0]     upc_next;
  uword_t               uw;
  op_t                  dp_op;
  dp_status_t           status;
  logic [MOD_BITS-1:0]  acc;
  logic [RESULT_W-1:0]  result;
  logic                 out_busy;
  logic                 take;

  assign uw            = ucode_rom(upc);
  assign s_axis_tready = (uw.op == OP_LOAD) && !rst;
  // take a modulus write only while idle and while no word is offered
  assign cfg_ready     = (upc == L_IDLE) && !s_axis_tvalid && !rst;
  assign out_busy      = m_axis_tvalid && !m_axis_tready;

  // a stored modulus below two counts as two
  assign mod_eff = (modulus < MOD_BITS'(2)) ? MOD_BITS'(2) : modulus;

  always_comb begin
    case (uw.cond)
      CND_ALWAYS:   take = 1'b1;
      CND_IN_IDLE:  take = !s_axis_tvalid;
      CND_RED_MORE: take = !status.red_last;
      CND_EXP_ZERO: take = status.exp_zero;
      CND_BIT_CLR:  take = !status.exp_bit0;
      CND_OUT_BUSY: take = out_busy;
      default:      take = 1'b0;
    endcase
    upc_next = take ? uw.target : upc + UPC_W'(1);
    dp_op    = (uw.op == OP_LOAD && !s_axis_tvalid) ? OP_NONE : uw.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc     <= L_IDLE;
      modulus <= MOD_BITS'(MODULUS_RESET);
    end else begin
      upc <= upc_next;
      if (cfg_valid && cfg_ready) begin
        modulus <= MOD_BITS'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (uw.op == OP_OUT && !out_busy) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.op == OP_OUT && !out_busy) begin
      result <= RESULT_W'(acc);
    end
  end

  assign m_axis_tdata = {1'b0, result};

  modexp_datapath #(
    .MOD_BITS(MOD_BITS)
  ) u_datapath (
    .clk            (clk),
    .op             (dp_op),
    .base_value     (s_axis_tdata[FIELD_W-1:0]),
    .exponent_value (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
    .modulus        (mod_eff),
    .acc            (acc),
    .status         (status)
  );

  // a fresh result is always fully reduced
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> (acc < mod_eff))
    else $error("result not below modulus");

  // an accepted word starts the program, so the input closes next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && upc == L_RED_BASE))
    else $error("sequencer did not leave idle after input word");

  // a reduction never runs past its last bit
  assert property (@(posedge clk) disable iff (rst)
    (uw.op == OP_RED_STEP && status.red_last) |=> (uw.op != OP_RED_STEP))
    else $error("reduction overran its step count");

endmodule
